### hdl/fmtl_pkg.sv
// Shared types, widths and the blend helper for the trilinear field map lookup.
// Used by fmtl_axis, fmtl_bank and field_map_trilinear_lookup; no dependencies.
package fmtl_pkg;

	// Field component width and the packed width of one grid point (Bx, By, Bz).
	localparam int unsigned COMP_W = 24;
	localparam int unsigned POINT_W = 3 * COMP_W;

	// Point count width (counts up to 127) and grid index width (indexes up to 63).
	localparam int unsigned NW = 7;
	localparam int unsigned IDX_W = 6;

	// Weight in Q.16, range 0..65536.
	localparam int unsigned WGT_W = 17;
	localparam logic [WGT_W-1:0] WGT_ONE = 17'h10000;

	// Intermediate blend width and the wide lerp result width.
	localparam int unsigned ACC_W = 42;
	localparam int unsigned LERP_W = 60;

	// Register map, by index of the register.
	typedef enum logic [2:0] {
		REG_ORIGIN_X = 3'd0,
		REG_ORIGIN_Y = 3'd1,
		REG_ORIGIN_Z = 3'd2,
		REG_SCALE_X = 3'd3,
		REG_SCALE_Y = 3'd4,
		REG_SCALE_Z = 3'd5,
		REG_GRID_DIMS = 3'd6,
		REG_INVERT = 3'd7
	} reg_idx_t;

	// Request kinds.
	typedef enum logic {
		REQ_WRITE = 1'b0,
		REQ_QUERY = 1'b1
	} req_kind_t;

	// Result of mapping one axis to a cell.
	typedef struct packed {
		logic in_grid;
		logic [IDX_W-1:0] idx;
		logic [WGT_W-1:0] w;
	} axis_map_t;

	// Linear blend a*(1-w) + b*w with w in Q.16.
	function automatic logic signed [LERP_W-1:0] lerp(
		input logic signed [ACC_W-1:0] a,
		input logic signed [ACC_W-1:0] b,
		input logic [WGT_W-1:0] w
	);
		logic signed [WGT_W:0] wb;
		logic signed [WGT_W:0] wa;
		logic signed [LERP_W-1:0] pa;
		logic signed [LERP_W-1:0] pb;
		wb = $signed({1'b0, w});
		wa = $signed({1'b0, WGT_ONE}) - wb;
		pa = LERP_W'(a) * LERP_W'(wa);
		pb = LERP_W'(b) * LERP_W'(wb);
		return pa + pb;
	endfunction

endpackage

### hdl/fmtl_axis.sv
// Three-stage mapping of one axis position to a cell index and Q.16 weight.
// Depends on fmtl_pkg; stages: offset, scale multiply, range check and mirror.
module fmtl_axis import fmtl_pkg::*; (
	input logic clk,
	input logic signed [31:0] pos,
	input logic signed [31:0] origin,
	input logic [31:0] scale,
	input logic [NW-1:0] n,
	input logic inv,
	output axis_map_t map_s3
);

	logic signed [32:0] d_s1;
	logic [63:0] c_s2;
	logic out_s2;

	logic [22:0] top;
	logic [22:0] cm;
	logic [NW-1:0] nm1;
	logic [NW-1:0] i_raw;
	axis_map_t map_d;

	// Offset from the grid origin.
	always_ff @(posedge clk) begin
		d_s1 <= 33'(pos) - 33'(origin);
	end

	// Scale into Q.16 cell units; a negative offset is outside unless scale is zero.
	always_ff @(posedge clk) begin
		out_s2 <= d_s1[32] && (scale != 32'd0);
		c_s2 <= d_s1[32] ? 64'd0 : (64'(d_s1[31:0]) * 64'(scale));
	end

	// Range check, mirror, and the top edge fold.
	always_comb begin
		nm1 = n - NW'(1);
		top = {nm1, 16'd0};
		cm = inv ? (top - c_s2[22:0]) : c_s2[22:0];
		i_raw = cm[22:16];
		map_d.in_grid = !out_s2 && (c_s2 <= 64'(top));
		if (i_raw >= nm1) begin
			map_d.idx = IDX_W'(n - NW'(2));
			map_d.w = WGT_ONE;
		end else begin
			map_d.idx = IDX_W'(i_raw);
			map_d.w = {1'b0, cm[15:0]};
		end
	end

	always_ff @(posedge clk) begin
		map_s3 <= map_d;
	end

endmodule

### hdl/fmtl_bank.sv
// One bank of the grid store: single port, registered read, one grid point per entry.
// Depends on fmtl_pkg for the point width.
module fmtl_bank import fmtl_pkg::*; #(
	parameter int unsigned DEPTH = 4096,
	parameter int unsigned AW = 12
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] addr,
	input logic [POINT_W-1:0] wdata,
	output logic [POINT_W-1:0] rdata
);

	logic [POINT_W-1:0] mem [DEPTH];

	// Write or read one entry per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

### hdl/field_map_trilinear_lookup.sv
// Top level of the trilinear field map lookup: config port, banked grid store, blend pipeline.
// Depends on fmtl_pkg, fmtl_axis and fmtl_bank.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  req     | req_valid/req_ready, req_type .. pos_z    | in
//  res     | res_valid/res_ready, field_bx .. inside_res| out
//  apb     | psel penable pwrite paddr pwdata prdata   | in/out
//
// One transaction per cycle is accepted while req_ready is high, writes and queries alike.
// A query result passes the axis mapping, the bank read and the blend stages, then enters
// the result queue; the eight corners come from eight parity banks, each read once per query,
// so the banked store sets the one-per-cycle rate.
// Grid writes commit in the same pipeline stage that issues the reads, so order is kept.
// A 16-entry result queue absorbs output stalls; req_ready drops once 16 queries are owed.
// Reset clears control and config only; the grid store is undefined until written.
module field_map_trilinear_lookup import fmtl_pkg::*; #(
	parameter int unsigned MAX_NX = 32,
	parameter int unsigned MAX_NY = 32,
	parameter int unsigned MAX_NZ = 32
) (
	input logic clk,
	input logic arst_n,
	input logic req_valid,
	output logic req_ready,
	input logic req_type,
	input logic [4:0] grid_ix,
	input logic [4:0] grid_iy,
	input logic [4:0] grid_iz,
	input logic signed [23:0] sample_bx,
	input logic signed [23:0] sample_by,
	input logic signed [23:0] sample_bz,
	input logic signed [31:0] pos_x,
	input logic signed [31:0] pos_y,
	input logic signed [31:0] pos_z,
	output logic res_valid,
	input logic res_ready,
	output logic signed [23:0] field_bx,
	output logic signed [23:0] field_by,
	output logic signed [23:0] field_bz,
	output logic inside_res,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [4:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int unsigned HX = (MAX_NX + 1) / 2;
	localparam int unsigned HY = (MAX_NY + 1) / 2;
	localparam int unsigned HZ = (MAX_NZ + 1) / 2;
	localparam int unsigned BANK_DEPTH = HX * HY * HZ;
	localparam int unsigned BANK_AW = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
	localparam int unsigned QDEPTH = 16;
	localparam int unsigned QAW = 4;
	localparam int unsigned RES_W = 3 * COMP_W + 1;

	// ------------------------------------------------------------------
	// Configuration registers.
	// ------------------------------------------------------------------
	logic signed [31:0] origin_x_q, origin_y_q, origin_z_q;
	logic [31:0] scale_x_q, scale_y_q, scale_z_q;
	logic [17:0] grid_dims_q;
	logic [2:0] invert_q;
	logic cfg_we;
	reg_idx_t cfg_idx;

	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign cfg_idx = reg_idx_t'(paddr[4:2]);

	// Register write on the access phase of an APB transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q <= '0;
			origin_y_q <= '0;
			origin_z_q <= '0;
			scale_x_q <= 32'd65536;
			scale_y_q <= 32'd65536;
			scale_z_q <= 32'd65536;
			grid_dims_q <= 18'd8322;
			invert_q <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ORIGIN_X: origin_x_q <= pwdata;
				REG_ORIGIN_Y: origin_y_q <= pwdata;
				REG_ORIGIN_Z: origin_z_q <= pwdata;
				REG_SCALE_X: scale_x_q <= pwdata;
				REG_SCALE_Y: scale_y_q <= pwdata;
				REG_SCALE_Z: scale_z_q <= pwdata;
				REG_GRID_DIMS: grid_dims_q <= pwdata[17:0];
				REG_INVERT: invert_q <= pwdata[2:0];
				default: ;
			endcase
		end
	end

	// Register readback.
	always_comb begin
		case (cfg_idx)
			REG_ORIGIN_X: prdata = origin_x_q;
			REG_ORIGIN_Y: prdata = origin_y_q;
			REG_ORIGIN_Z: prdata = origin_z_q;
			REG_SCALE_X: prdata = scale_x_q;
			REG_SCALE_Y: prdata = scale_y_q;
			REG_SCALE_Z: prdata = scale_z_q;
			REG_GRID_DIMS: prdata = {14'd0, grid_dims_q};
			REG_INVERT: prdata = {29'd0, invert_q};
			default: prdata = '0;
		endcase
	end

	// Point counts, clamped to 2..MAX.
	function automatic logic [NW-1:0] clamp_dim(input logic [5:0] f, input logic [NW-1:0] mx);
		logic [NW-1:0] v;
		v = NW'(f);
		if (v < NW'(2)) begin
			v = NW'(2);
		end
		if (v > mx) begin
			v = mx;
		end
		return v;
	endfunction

	logic [NW-1:0] nx, ny, nz;
	assign nx = clamp_dim(grid_dims_q[5:0], NW'(MAX_NX));
	assign ny = clamp_dim(grid_dims_q[11:6], NW'(MAX_NY));
	assign nz = clamp_dim(grid_dims_q[17:12], NW'(MAX_NZ));

	// ------------------------------------------------------------------
	// Acceptance and result credits.
	// ------------------------------------------------------------------
	logic req_fire, res_fire;
	logic [QAW:0] credit_q;

	assign req_ready = (credit_q < (QAW+1)'(QDEPTH));
	assign req_fire = req_valid && req_ready;
	assign res_fire = res_valid && res_ready;

	// Count queries accepted whose results are not yet taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			credit_q <= '0;
		end else begin
			case ({req_fire && (req_type == REQ_QUERY), res_fire})
				2'b10: credit_q <= credit_q + 1'b1;
				2'b01: credit_q <= credit_q - 1'b1;
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// Stages 1 to 3: axis mapping, with the write payload alongside.
	// ------------------------------------------------------------------
	axis_map_t map_x_s3, map_y_s3, map_z_s3;

	fmtl_axis u_axis_x (
		.clk(clk), .pos(pos_x), .origin(origin_x_q), .scale(scale_x_q),
		.n(nx), .inv(invert_q[0]), .map_s3(map_x_s3)
	);
	fmtl_axis u_axis_y (
		.clk(clk), .pos(pos_y), .origin(origin_y_q), .scale(scale_y_q),
		.n(ny), .inv(invert_q[1]), .map_s3(map_y_s3)
	);
	fmtl_axis u_axis_z (
		.clk(clk), .pos(pos_z), .origin(origin_z_q), .scale(scale_z_q),
		.n(nz), .inv(invert_q[2]), .map_s3(map_z_s3)
	);

	logic v_s1, v_s2, v_s3;
	logic qry_s1, qry_s2, qry_s3;
	logic [14:0] gidx_s1, gidx_s2, gidx_s3;
	logic [POINT_W-1:0] gdat_s1, gdat_s2, gdat_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= req_fire;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		qry_s1 <= req_type;
		qry_s2 <= qry_s1;
		qry_s3 <= qry_s2;
		gidx_s1 <= {grid_ix, grid_iy, grid_iz};
		gidx_s2 <= gidx_s1;
		gidx_s3 <= gidx_s2;
		gdat_s1 <= {sample_bz, sample_by, sample_bx};
		gdat_s2 <= gdat_s1;
		gdat_s3 <= gdat_s2;
	end

	// ------------------------------------------------------------------
	// Stage 3: bank access. Bank {px,py,pz} holds points of that index parity.
	// ------------------------------------------------------------------
	logic [4:0] gx, gy, gz;
	logic wr_ok;
	logic [POINT_W-1:0] rdata_s4 [8];

	assign gx = gidx_s3[14:10];
	assign gy = gidx_s3[9:5];
	assign gz = gidx_s3[4:0];
	assign wr_ok = v_s3 && (qry_s3 == REQ_WRITE) && (NW'(gx) < NW'(MAX_NX))
		&& (NW'(gy) < NW'(MAX_NY)) && (NW'(gz) < NW'(MAX_NZ));

	// Half-index of the corner whose parity matches the bank.
	function automatic logic [IDX_W-1:0] half_idx(input logic [IDX_W-1:0] i, input logic p);
		logic [IDX_W:0] s;
		s = (IDX_W+1)'(i) + (IDX_W+1)'(i[0] ^ p);
		return s[IDX_W:1];
	endfunction

	for (genvar b = 0; b < 8; b++) begin : g_bank
		localparam logic [2:0] BID = 3'(b);
		logic [IDX_W-1:0] hx, hy, hz;
		logic [BANK_AW-1:0] addr;
		logic we;

		always_comb begin
			if (qry_s3 == REQ_QUERY) begin
				hx = half_idx(map_x_s3.idx, BID[2]);
				hy = half_idx(map_y_s3.idx, BID[1]);
				hz = half_idx(map_z_s3.idx, BID[0]);
			end else begin
				hx = IDX_W'(gx[4:1]);
				hy = IDX_W'(gy[4:1]);
				hz = IDX_W'(gz[4:1]);
			end
			addr = BANK_AW'((hx * HY + hy) * HZ + hz);
			we = wr_ok && ({gx[0], gy[0], gz[0]} == BID);
		end

		fmtl_bank #(.DEPTH(BANK_DEPTH), .AW(BANK_AW)) u_bank (
			.clk(clk), .we(we), .addr(addr), .wdata(gdat_s3), .rdata(rdata_s4[b])
		);
	end

	// Query side data that travels with the reads.
	logic q_s4, q_s5, q_s6, q_s7;
	logic ins_s4, ins_s5, ins_s6, ins_s7;
	logic [2:0] par_s4;
	logic [WGT_W-1:0] wx_s4, wy_s4, wz_s4, wx_s5, wy_s5, wx_s6;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_s4 <= 1'b0;
			q_s5 <= 1'b0;
			q_s6 <= 1'b0;
			q_s7 <= 1'b0;
		end else begin
			q_s4 <= v_s3 && (qry_s3 == REQ_QUERY);
			q_s5 <= q_s4;
			q_s6 <= q_s5;
			q_s7 <= q_s6;
		end
	end

	always_ff @(posedge clk) begin
		ins_s4 <= map_x_s3.in_grid && map_y_s3.in_grid && map_z_s3.in_grid;
		par_s4 <= {map_x_s3.idx[0], map_y_s3.idx[0], map_z_s3.idx[0]};
		wx_s4 <= map_x_s3.w;
		wy_s4 <= map_y_s3.w;
		wz_s4 <= map_z_s3.w;
		ins_s5 <= ins_s4;
		wx_s5 <= wx_s4;
		wy_s5 <= wy_s4;
		ins_s6 <= ins_s5;
		wx_s6 <= wx_s5;
		ins_s7 <= ins_s6;
	end

	// ------------------------------------------------------------------
	// Stages 4 to 6: blend along z, then y with rounding, then x with rounding and saturation.
	// ------------------------------------------------------------------
	logic signed [ACC_W-1:0] z_s5 [3][2][2];
	logic signed [ACC_W-1:0] ex_s6 [3][2];
	logic signed [COMP_W-1:0] f_s7 [3];

	// Along z: corner (a, b, c) lives in bank {px^a, py^b, pz^c}.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int a = 0; a < 2; a++) begin
				for (int b = 0; b < 2; b++) begin
					z_s5[k][a][b] <= ACC_W'(lerp(
						ACC_W'($signed(rdata_s4[{par_s4[2] ^ a[0], par_s4[1] ^ b[0],
							par_s4[0]}][k*COMP_W +: COMP_W])),
						ACC_W'($signed(rdata_s4[{par_s4[2] ^ a[0], par_s4[1] ^ b[0],
							~par_s4[0]}][k*COMP_W +: COMP_W])),
						wz_s4));
				end
			end
		end
	end

	// Along y, rounded back to Q.16.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			for (int a = 0; a < 2; a++) begin
				ex_s6[k][a] <= ACC_W'((lerp(z_s5[k][a][0], z_s5[k][a][1], wy_s5)
					+ LERP_W'(64'sd32768)) >>> 16);
			end
		end
	end

	// Along x, rounded to an integer and saturated.
	always_ff @(posedge clk) begin
		for (int k = 0; k < 3; k++) begin
			logic signed [LERP_W-1:0] r;
			r = (lerp(ex_s6[k][0], ex_s6[k][1], wx_s6) + LERP_W'(64'sd2147483648)) >>> 32;
			if (r > LERP_W'(64'sd8388607)) begin
				f_s7[k] <= 24'sh7FFFFF;
			end else if (r < -LERP_W'(64'sd8388608)) begin
				f_s7[k] <= 24'sh800000;
			end else begin
				f_s7[k] <= COMP_W'(r);
			end
		end
	end

	// ------------------------------------------------------------------
	// Result queue.
	// ------------------------------------------------------------------
	logic [RES_W-1:0] rq_mem [QDEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QAW:0] cnt_q;
	logic [RES_W-1:0] rq_head;

	always_ff @(posedge clk) begin
		if (q_s7) begin
			rq_mem[wp_q] <= ins_s7 ? {1'b1, f_s7[2], f_s7[1], f_s7[0]} : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
			cnt_q <= '0;
		end else begin
			if (q_s7) begin
				wp_q <= wp_q + 1'b1;
			end
			if (res_fire) begin
				rp_q <= rp_q + 1'b1;
			end
			case ({q_s7, res_fire})
				2'b10: cnt_q <= cnt_q + 1'b1;
				2'b01: cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
		end
	end

	assign rq_head = rq_mem[rp_q];
	assign res_valid = (cnt_q != '0);
	assign inside_res = rq_head[RES_W-1];
	assign field_bz = rq_head[3*COMP_W-1:2*COMP_W];
	assign field_by = rq_head[2*COMP_W-1:COMP_W];
	assign field_bx = rq_head[COMP_W-1:0];

`ifndef SYNTHESIS
	// The queue never receives a result while full, unless a result is taken in the same cycle.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_s7 |-> (cnt_q < (QAW+1)'(QDEPTH) || res_fire))
		else $error("result queue overflow");

	// Queued results never exceed the queries owed.
	a_credit_cover: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= credit_q)
		else $error("result queue holds more than owed");

	// A query accepted now is carried through v_s1 to v_s3 and q_s4 to q_s7 without loss.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(req_fire && req_type == REQ_QUERY) |-> ##7 q_s7)
		else $error("query result lost in pipeline");
`endif

endmodule
